// ----- src/lss_pkg.sv -----
// Shared types, constants and the build-time Lanczos-3 weight table for the line shader.
package lss_pkg;

  localparam int FRAC_BITS        = 8;
  localparam int COLUMN_BITS      = 12;
  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int X_POS_W   = 20;
  localparam int ROW_W     = 12;
  localparam int BASE_W    = X_POS_W - FRAC_BITS;
  localparam int TAPS      = 6;
  localparam int TAP_W     = 3;
  localparam int ROM_DEPTH = TAPS << FRAC_BITS;
  localparam int ROM_AW    = TAP_W + FRAC_BITS;
  localparam int WEIGHT_W  = 16;
  localparam int COLOUR_W  = 24;

  localparam logic [1:0] REQ_WIDE  = 2'd0;
  localparam logic [1:0] REQ_SPLIT = 2'd1;
  localparam logic [1:0] REQ_THIN  = 2'd2;

  localparam logic [1:0] REG_LOW_A  = 2'd0;
  localparam logic [1:0] REG_HIGH_A = 2'd1;
  localparam logic [1:0] REG_LOW_B  = 2'd2;
  localparam logic [1:0] REG_HIGH_B = 2'd3;

  localparam logic [TAP_W-1:0] TAP_FIRST  = 3'd0;
  localparam logic [TAP_W-1:0] TAP_CENTRE = 3'd2;
  localparam logic [TAP_W-1:0] TAP_RIGHT  = 3'd3;
  localparam logic [TAP_W-1:0] TAP_LAST   = 3'd5;

  localparam logic [63:0] PI_Q30       = 64'd3373259426;
  localparam logic [63:0] HALF_TURN    = 64'(3 << FRAC_BITS);
  localparam logic [63:0] FULL_TURN    = 64'(6 << FRAC_BITS);
  localparam logic [63:0] QUARTER_TURN = HALF_TURN / 64'd2;
  localparam int          P_SHIFT      = 48 - WEIGHT_FRAC_BITS;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [X_POS_W-1:0] x_pos;
    logic [ROW_W-1:0]   row_start;
    logic [ROW_W-1:0]   row_end;
  } lss_in_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] column;
    logic [ROW_W-1:0]       span_top;
    logic [ROW_W-1:0]       span_bottom;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             alpha;
    logic                   last;
  } lss_out_t;

  typedef logic [ROM_DEPTH-1:0][WEIGHT_W-1:0] lss_rom_t;

  function automatic logic [63:0] lss_udiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] lss_sdiv(logic signed [63:0] num, logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = num[63] ? 64'(-num) : 64'(num);
    q   = lss_udiv(mag, den);
    return num[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] lss_div1024(logic signed [63:0] num);
    logic [63:0] mag;
    mag = num[63] ? 64'(-num) : 64'(num);
    mag = mag >> 10;
    return num[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] lss_taylor_sin(logic [63:0] th);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (th * th) >> 30;
    term = th;
    sum  = $signed(th);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    return sum;
  endfunction

  function automatic logic signed [63:0] lss_half_turn_sin(logic [63:0] m);
    logic [63:0]        mm;
    logic               neg;
    logic [63:0]        th;
    logic signed [63:0] s;
    mm  = m % FULL_TURN;
    neg = 1'b0;
    if (mm >= HALF_TURN) begin
      neg = 1'b1;
      mm  = mm - HALF_TURN;
    end
    if (mm > QUARTER_TURN) begin
      mm = HALF_TURN - mm;
    end
    th = (PI_Q30 * mm + QUARTER_TURN) / HALF_TURN;
    s  = lss_taylor_sin(th);
    return neg ? -s : s;
  endfunction

  function automatic logic [WEIGHT_W-1:0] lss_weight(int u);
    logic [63:0]        v;
    logic [63:0]        da;
    logic [63:0]        db;
    logic [63:0]        pmag;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] p;
    logic signed [63:0] r;
    v = (u < 0) ? 64'(-u) : 64'(u);
    if (v == 64'd0) begin
      return ((1 << WEIGHT_FRAC_BITS) > 32767) ? 16'h7FFF : WEIGHT_W'(1 << WEIGHT_FRAC_BITS);
    end
    if (v >= HALF_TURN) begin
      return '0;
    end
    da   = (PI_Q30 * v + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    db   = (PI_Q30 * v + QUARTER_TURN) / HALF_TURN;
    sa   = lss_sdiv(lss_div1024(lss_half_turn_sin(64'd3 * v)) <<< 34, da);
    sb   = lss_sdiv(lss_div1024(lss_half_turn_sin(v)) <<< 34, db);
    p    = sa * sb;
    pmag = p[63] ? 64'(-p) : 64'(p);
    pmag = (pmag + (64'd1 << (P_SHIFT - 1))) >> P_SHIFT;
    r    = p[63] ? -$signed(pmag) : $signed(pmag);
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return r[WEIGHT_W-1:0];
  endfunction

  function automatic lss_rom_t lss_build_rom();
    lss_rom_t rom;
    int       u;
    rom = '0;
    for (int k = 0; k < TAPS; k++) begin
      for (int f = 0; f < (1 << FRAC_BITS); f++) begin
        u = (k - 2) * (1 << FRAC_BITS) - f;
        rom[(k << FRAC_BITS) + f] = lss_weight(u);
      end
    end
    return rom;
  endfunction

endpackage

// ----- src/lanczos_subpixel_line_shader.sv -----
// Top level of the Lanczos-3 subpixel line shader: sequencer, weight ROM and blend stage.
//
// Use: an item (a line's mode, 12.8 fixed-point x position and row span) is offered on
// in_item with start and taken at a clock edge where start is high and busy is low. The
// block answers with one result per coloured column on out_item, each shown for exactly
// one cycle with out_valid high; the final result of a line carries last. Wide and split
// lines give six columns, thin lines one or two, and a line whose base column is below
// two in the wide and split modes, or an unused mode code, gives none.
// Timing: an accepted item passes through the sequencer registers, then the ROM output and
// stage one registers, then the result register. One tap is read from the single-port
// weight ROM per cycle. The next item is taken in the cycle its predecessor reads its last
// tap, so results of consecutive items follow without a gap. The colour registers sit on an
// APB-style port at byte addresses 0, 4, 8 and 12; the user must write them only while the
// block is idle, as the block itself does not enforce this. Reset sets the low colours to
// white and the high colours to black and drops any item in flight. Results cannot be held
// off.
module lanczos_subpixel_line_shader (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lss_pkg::lss_in_t  in_item,
  output logic              out_valid,
  output lss_pkg::lss_out_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lss_pkg::*;

  localparam lss_rom_t KERNEL_ROM = lss_build_rom();

  logic [COLOUR_W-1:0] low_a_r, high_a_r, low_b_r, high_b_r;
  logic                cfg_wr;

  logic                   act_r, act_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic [ROW_W-1:0]       top_r, top_nxt;
  logic [ROW_W-1:0]       bot_r, bot_nxt;
  logic [TAP_W-1:0]       tap_r, tap_nxt;
  logic [TAP_W-1:0]       tap_end_r, tap_end_nxt;

  logic                   accept;
  logic                   issue_last;
  logic                   item_ok;
  logic [BASE_W-1:0]      in_base;
  logic [FRAC_BITS-1:0]   in_frac;
  logic [ROM_AW-1:0]      rom_addr;

  logic                   s1_valid_r;
  logic [COLUMN_BITS-1:0] s1_column_r;
  logic [ROW_W-1:0]       s1_top_r, s1_bot_r;
  logic                   s1_sel_b_r, s1_last_r;
  logic [WEIGHT_W-1:0]    rom_q_r;

  logic [COLOUR_W-1:0]    blend_low, blend_high;
  logic [7:0]             red_v, green_v, blue_v, alpha_v;
  logic                   out_valid_r;
  lss_out_t               out_item_r, out_item_nxt;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_a_r  <= '1;
      high_a_r <= '0;
      low_b_r  <= '1;
      high_b_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOW_A:  low_a_r  <= pwdata[COLOUR_W-1:0];
        REG_HIGH_A: high_a_r <= pwdata[COLOUR_W-1:0];
        REG_LOW_B:  low_b_r  <= pwdata[COLOUR_W-1:0];
        REG_HIGH_B: high_b_r <= pwdata[COLOUR_W-1:0];
        default:    low_a_r  <= low_a_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOW_A:  prdata = {{(32 - COLOUR_W){1'b0}}, low_a_r};
      REG_HIGH_A: prdata = {{(32 - COLOUR_W){1'b0}}, high_a_r};
      REG_LOW_B:  prdata = {{(32 - COLOUR_W){1'b0}}, low_b_r};
      REG_HIGH_B: prdata = {{(32 - COLOUR_W){1'b0}}, high_b_r};
      default:    prdata = '0;
    endcase
  end

  // Tap sequencer
  assign in_base    = in_item.x_pos[X_POS_W-1:FRAC_BITS];
  assign in_frac    = in_item.x_pos[FRAC_BITS-1:0];
  assign issue_last = act_r && (tap_r == tap_end_r);
  assign busy       = act_r && !issue_last;
  assign accept     = start && !busy;
  assign item_ok    = (in_item.req_type == REQ_THIN) ||
                      (((in_item.req_type == REQ_WIDE) || (in_item.req_type == REQ_SPLIT)) &&
                       (in_base >= BASE_W'(2)));

  always_comb begin
    act_nxt     = act_r;
    mode_nxt    = mode_r;
    base_nxt    = base_r;
    frac_nxt    = frac_r;
    top_nxt     = top_r;
    bot_nxt     = bot_r;
    tap_nxt     = tap_r;
    tap_end_nxt = tap_end_r;
    if (accept) begin
      act_nxt  = item_ok;
      mode_nxt = in_item.req_type;
      base_nxt = in_base;
      frac_nxt = in_frac;
      top_nxt  = in_item.row_start;
      bot_nxt  = in_item.row_end;
      if (in_item.req_type == REQ_THIN) begin
        tap_nxt     = TAP_CENTRE;
        tap_end_nxt = (in_frac == '0) ? TAP_CENTRE : TAP_RIGHT;
      end else begin
        tap_nxt     = TAP_FIRST;
        tap_end_nxt = TAP_LAST;
      end
    end else if (issue_last) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      tap_nxt = tap_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    base_r    <= base_nxt;
    frac_r    <= frac_nxt;
    top_r     <= top_nxt;
    bot_r     <= bot_nxt;
    tap_r     <= tap_nxt;
    tap_end_r <= tap_end_nxt;
  end

  // Weight ROM read and stage one
  assign rom_addr = {tap_r, frac_r};

  always_ff @(posedge clk) begin
    rom_q_r <= KERNEL_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_column_r <= COLUMN_BITS'(base_r) + COLUMN_BITS'(tap_r) - COLUMN_BITS'(2);
    s1_top_r    <= top_r;
    s1_bot_r    <= bot_r;
    s1_sel_b_r  <= (mode_r == REQ_SPLIT) && (tap_r >= TAP_RIGHT);
    s1_last_r   <= (tap_r == tap_end_r);
  end

  // Blend stage
  assign blend_low  = s1_sel_b_r ? low_b_r  : low_a_r;
  assign blend_high = s1_sel_b_r ? high_b_r : high_a_r;

  lss_blend u_blend_red (
    .low    (blend_low[23:16]),
    .high   (blend_high[23:16]),
    .weight ($signed(rom_q_r)),
    .value  (red_v)
  );

  lss_blend u_blend_green (
    .low    (blend_low[15:8]),
    .high   (blend_high[15:8]),
    .weight ($signed(rom_q_r)),
    .value  (green_v)
  );

  lss_blend u_blend_blue (
    .low    (blend_low[7:0]),
    .high   (blend_high[7:0]),
    .weight ($signed(rom_q_r)),
    .value  (blue_v)
  );

  lss_blend u_blend_alpha (
    .low    (8'd0),
    .high   (8'd255),
    .weight ($signed(rom_q_r)),
    .value  (alpha_v)
  );

  always_comb begin
    out_item_nxt.column      = s1_column_r;
    out_item_nxt.span_top    = s1_top_r;
    out_item_nxt.span_bottom = s1_bot_r;
    out_item_nxt.red         = red_v;
    out_item_nxt.green       = green_v;
    out_item_nxt.blue        = blue_v;
    out_item_nxt.alpha       = alpha_v;
    out_item_nxt.last        = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- src/lss_blend.sv -----
// One colour channel blend: low plus the weighted difference, rounded and clamped to a byte.
module lss_blend (
  input  logic [7:0]                           low,
  input  logic [7:0]                           high,
  input  logic signed [lss_pkg::WEIGHT_W-1:0]  weight,
  output logic [7:0]                           value
);
  import lss_pkg::*;

  localparam int PROD_W = WEIGHT_W + 9;
  localparam int T_W    = (WEIGHT_FRAC_BITS > 16 ? WEIGHT_FRAC_BITS : 16) + 11;
  localparam logic signed [T_W-1:0] ROUND_HALF = T_W'(1) <<< (WEIGHT_FRAC_BITS - 1);

  logic signed [8:0]        diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [T_W-1:0]    low_scaled;
  logic signed [T_W-1:0]    t;

  always_comb begin
    diff       = $signed({1'b0, high}) - $signed({1'b0, low});
    prod       = PROD_W'(diff) * PROD_W'(weight);
    low_scaled = $signed({{(T_W - 8 - WEIGHT_FRAC_BITS){1'b0}}, low, {WEIGHT_FRAC_BITS{1'b0}}});
    t          = low_scaled + {{(T_W - PROD_W){prod[PROD_W-1]}}, prod} + ROUND_HALF;
    if (t[T_W-1]) begin
      value = 8'd0;
    end else if (|t[T_W-2:WEIGHT_FRAC_BITS+8]) begin
      value = 8'd255;
    end else begin
      value = t[WEIGHT_FRAC_BITS+7:WEIGHT_FRAC_BITS];
    end
  end

endmodule

// ----- src/lss_checker.sv -----
// Port-level checks on the line shader's reset, busy and result sequencing, bound to the top level.
module lss_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input lss_pkg::lss_out_t out_item
);
  import lss_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (!out_valid && !busy))
    else $error("result or busy seen straight after reset");

  a_line_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |=> out_valid)
    else $error("a line's results were broken up before its last item");

  a_column_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |=>
      ((out_item.column == $past(out_item.column) + 1'b1) &&
       $stable(out_item.span_top) && $stable(out_item.span_bottom)))
    else $error("column or span did not follow within a line");

  a_busy_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> ($past(start) || $past(busy)))
    else $error("busy raised without an accepted item");

endmodule

bind lanczos_subpixel_line_shader lss_checker u_lss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- test/tb.sv -----
// Self-checking testbench for the Lanczos-3 subpixel line shader.
module tb;
  import lss_pkg::*;

  typedef longint unsigned u64_t;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         SETTLE_TICKS = 8;
  localparam int         PHASES       = 6;
  localparam int         RANDOM_LINES = 72;
  localparam int         IN_W         = $bits(lss_in_t);

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  lss_in_t  in_item = '0;
  logic     out_valid;
  lss_out_t out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          tap_weight [ROM_DEPTH];
  logic [23:0] colour_reg [4];
  lss_in_t     line_queue [$];
  lss_out_t    pixel_queue [$];
  lss_out_t    want_pixel;
  int          sender_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned stall_ticks = 0;

  lanczos_subpixel_line_shader u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic longint taylor_sin_q30(u64_t th);
    u64_t   x2;
    u64_t   term;
    longint sum;
    x2   = (th * th) >> 30;
    term = th;
    sum  = longint'(th);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  function automatic longint sin_of_turn(u64_t m);
    u64_t   mm;
    logic   neg;
    u64_t   th;
    longint s;
    mm  = m % (2 * HALF_TURN);
    neg = 1'b0;
    if (mm >= HALF_TURN) begin
      neg = 1'b1;
      mm  = mm - HALF_TURN;
    end
    if (mm > HALF_TURN / 2) begin
      mm = HALF_TURN - mm;
    end
    th = (PI_Q30 * mm + HALF_TURN / 2) / HALF_TURN;
    s  = taylor_sin_q30(th);
    return neg ? -s : s;
  endfunction

  function automatic int lanczos_tap(int u);
    u64_t   v;
    longint da;
    longint db;
    longint sa;
    longint sb;
    longint p;
    longint r;
    longint div;
    v   = (u < 0) ? u64_t'(-u) : u64_t'(u);
    div = 64'sd1 <<< (48 - WEIGHT_FRAC_BITS);
    if (v == 0) begin
      return 1 << WEIGHT_FRAC_BITS;
    end
    if (v >= HALF_TURN) begin
      return 0;
    end
    da = longint'((PI_Q30 * v + (1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    db = longint'((PI_Q30 * v + HALF_TURN / 2) / HALF_TURN);
    sa = (sin_of_turn(3 * v) / 1024) * (64'sd1 <<< 34) / da;
    sb = (sin_of_turn(v) / 1024) * (64'sd1 <<< 34) / db;
    p  = sa * sb;
    if (p >= 0) begin
      r = (p + div / 2) / div;
    end else begin
      r = -((-p + div / 2) / div);
    end
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    return int'(r);
  endfunction

  function automatic logic [7:0] mix_channel(int lo, int hi, int w);
    longint t;
    t = longint'(lo) * (64'sd1 <<< WEIGHT_FRAC_BITS) + longint'(hi - lo) * w
        + (64'sd1 <<< (WEIGHT_FRAC_BITS - 1));
    if (t < 0) begin
      return 8'd0;
    end
    t = t >>> WEIGHT_FRAC_BITS;
    return (t > 255) ? 8'd255 : 8'(t);
  endfunction

  function automatic lss_out_t shade_column(logic [COLUMN_BITS-1:0] col, int tap,
                                            logic [7:0] frac, logic [23:0] lo,
                                            logic [23:0] hi, lss_in_t ln, logic fin);
    lss_out_t px;
    int       w;
    w              = tap_weight[(tap << FRAC_BITS) + frac];
    px.column      = col;
    px.span_top    = ln.row_start;
    px.span_bottom = ln.row_end;
    px.red         = mix_channel(lo[23:16], hi[23:16], w);
    px.green       = mix_channel(lo[15:8], hi[15:8], w);
    px.blue        = mix_channel(lo[7:0], hi[7:0], w);
    px.alpha       = mix_channel(0, 255, w);
    px.last        = fin;
    return px;
  endfunction

  function automatic void shade_line(lss_in_t ln);
    logic [BASE_W-1:0]    base;
    logic [FRAC_BITS-1:0] frac;
    logic                 right;
    base = ln.x_pos[X_POS_W-1:FRAC_BITS];
    frac = ln.x_pos[FRAC_BITS-1:0];
    if (ln.req_type == REQ_WIDE || ln.req_type == REQ_SPLIT) begin
      if (base < 2) begin
        return;
      end
      for (int k = 0; k < TAPS; k++) begin
        right = (ln.req_type == REQ_SPLIT) && k >= TAP_RIGHT;
        pixel_queue.push_back(shade_column(COLUMN_BITS'(base - 2 + k), k, frac,
                              right ? colour_reg[REG_LOW_B] : colour_reg[REG_LOW_A],
                              right ? colour_reg[REG_HIGH_B] : colour_reg[REG_HIGH_A],
                              ln, k == TAP_LAST));
      end
    end else if (ln.req_type == REQ_THIN) begin
      pixel_queue.push_back(shade_column(base, TAP_CENTRE, frac, colour_reg[REG_LOW_A],
                                         colour_reg[REG_HIGH_A], ln, frac == 0));
      if (frac != 0) begin
        pixel_queue.push_back(shade_column(COLUMN_BITS'(base + 1), TAP_RIGHT, frac,
                                           colour_reg[REG_LOW_A], colour_reg[REG_HIGH_A],
                                           ln, 1'b1));
      end
    end
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic lss_in_t random_line();
    lss_in_t ln;
    int      pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      ln.req_type = REQ_UNUSED;
    end else if (pick < 8) begin
      ln.req_type = REQ_WIDE;
    end else if (pick < 14) begin
      ln.req_type = REQ_SPLIT;
    end else begin
      ln.req_type = REQ_THIN;
    end
    if ($urandom_range(0, 9) == 0) begin
      ln.x_pos = X_POS_W'($urandom_range(0, 'h3FF));
    end else begin
      ln.x_pos = X_POS_W'($urandom);
    end
    if ($urandom_range(0, 7) == 0) begin
      ln.x_pos[FRAC_BITS-1:0] = '0;
    end
    ln.row_start = ROW_W'($urandom);
    ln.row_end   = ROW_W'($urandom);
    return ln;
  endfunction

  task automatic queue_line(logic [1:0] kind, logic [X_POS_W-1:0] x,
                            logic [ROW_W-1:0] top, logic [ROW_W-1:0] bot);
    lss_in_t ln;
    ln.req_type  = kind;
    ln.x_pos     = x;
    ln.row_start = top;
    ln.row_end   = bot;
    line_queue.push_back(ln);
  endtask

  task automatic write_colour(logic [1:0] idx, logic [23:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {8'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    colour_reg[idx] = value;
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (line_queue.size() != 0 || start || pixel_queue.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        shade_line(in_item);
      end
      if (!start || !busy) begin
        if (line_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_item <= line_queue.pop_front();
          start   <= 1'b1;
        end else begin
          in_item <= lss_in_t'(IN_W'({$urandom, $urandom}));
          start   <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pixel_queue.size() == 0) begin
        $error("column %0d arrived with no item pending", out_item.column);
        mismatches++;
      end else begin
        want_pixel = pixel_queue.pop_front();
        mismatches += field_differs("column", want_pixel.column, out_item.column);
        mismatches += field_differs("span_top", want_pixel.span_top, out_item.span_top);
        mismatches += field_differs("span_bottom", want_pixel.span_bottom,
                                    out_item.span_bottom);
        mismatches += field_differs("red", want_pixel.red, out_item.red);
        mismatches += field_differs("green", want_pixel.green, out_item.green);
        mismatches += field_differs("blue", want_pixel.blue, out_item.blue);
        mismatches += field_differs("alpha", want_pixel.alpha, out_item.alpha);
        mismatches += field_differs("last", want_pixel.last, out_item.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_ticks <= 0;
      end else begin
        stall_ticks <= stall_ticks + 1;
      end
      if (stall_ticks >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int      counted;
    lss_in_t ln;
    for (int k = 0; k < TAPS; k++) begin
      for (int f = 0; f < (1 << FRAC_BITS); f++) begin
        tap_weight[(k << FRAC_BITS) + f] = lanczos_tap((k - 2) * (1 << FRAC_BITS) - f);
      end
    end
    colour_reg[REG_LOW_A]  = 24'hFFFFFF;
    colour_reg[REG_HIGH_A] = 24'h000000;
    colour_reg[REG_LOW_B]  = 24'hFFFFFF;
    colour_reg[REG_HIGH_B] = 24'h000000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1: begin
            write_colour(REG_LOW_A, 24'h000000);
            write_colour(REG_HIGH_A, 24'hFFFFFF);
            write_colour(REG_LOW_B, 24'hFFFFFF);
            write_colour(REG_HIGH_B, 24'h000000);
          end
          4: begin
            write_colour(REG_LOW_A, 24'hFFFFFF);
            write_colour(REG_HIGH_A, 24'hFFFFFF);
            write_colour(REG_LOW_B, 24'h000000);
            write_colour(REG_HIGH_B, 24'h000000);
          end
          default: begin
            write_colour(REG_LOW_A, 24'($urandom));
            write_colour(REG_HIGH_A, 24'($urandom));
            write_colour(REG_LOW_B, 24'($urandom));
            write_colour(REG_HIGH_B, 24'($urandom));
          end
        endcase
      end
      case (phase)
        1, 4:    sender_idle_pct = 60;
        3:       sender_idle_pct = 31;
        default: sender_idle_pct = 0;
      endcase

      if (phase == 0) begin
        queue_line(REQ_WIDE, 20'h00000, 12'd0, 12'd4095);
        queue_line(REQ_WIDE, 20'h001FF, 12'd4095, 12'd0);
        queue_line(REQ_WIDE, 20'h00200, 12'd0, 12'd0);
        queue_line(REQ_WIDE, 20'hFFFFF, 12'd4095, 12'd4095);
        queue_line(REQ_WIDE, 20'h12380, 12'hAAA, 12'h555);
        queue_line(REQ_WIDE, 20'h00201, 12'h555, 12'hAAA);
        queue_line(REQ_SPLIT, 20'h00200, 12'd1, 12'd2);
        queue_line(REQ_SPLIT, 20'hFFFFF, 12'd4095, 12'd0);
        queue_line(REQ_SPLIT, 20'h001FF, 12'd7, 12'd9);
        queue_line(REQ_SPLIT, 20'h45678, 12'd100, 12'd200);
        queue_line(REQ_THIN, 20'h00000, 12'd0, 12'd4095);
        queue_line(REQ_THIN, 20'h000FF, 12'd3, 12'd3);
        queue_line(REQ_THIN, 20'hFFF00, 12'd4095, 12'd4095);
        queue_line(REQ_THIN, 20'hFFFFF, 12'd0, 12'd0);
        queue_line(REQ_THIN, 20'h12345, 12'hF0F, 12'h0F0);
        queue_line(REQ_UNUSED, 20'h54321, 12'd10, 12'd20);
        queue_line(REQ_UNUSED, 20'hFFFFF, 12'd4095, 12'd4095);
        queue_line(REQ_WIDE, 20'h00380, 12'd5, 12'd6);
      end

      counted = 0;
      while (counted < RANDOM_LINES) begin
        ln = random_line();
        line_queue.push_back(ln);
        if (ln.req_type != REQ_UNUSED) begin
          counted++;
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lss_pkg.sv
src/lss_blend.sv
src/lanczos_subpixel_line_shader.sv
src/lss_checker.sv
test/tb.sv
